>>> hw/rtl/lphs_pkg.sv
package lphs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int REM_W       = CNT_W + 1;

  // Field widths
  localparam int ACT_W    = 2;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int USED_W   = 7;
  localparam int SIZE_W   = 7;

  // Remainder unit: DIV_BITS dividend bits retired per cycle
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = (KEY_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DSH_W     = DIV_STEPS * DIV_BITS;
  localparam int DCNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Request actions
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_INSERT,
    S_SEARCH,
    S_PUSH
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic clear;
    logic misc;
    logic div_step;
    logic ins_step;
    logic srch_step;
    logic push;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic ins_done;
    logic srch_done;
    logic out_busy;
  } dp_sts_t;

endpackage

>>> hw/rtl/lphs_req_if.sv
interface lphs_req_if;
  logic                         valid;
  logic                         ready;
  logic [lphs_pkg::ACT_W-1:0]   action;
  logic [lphs_pkg::KEY_W-1:0]   key_value;

  modport source (output valid, action, key_value, input ready);
  modport sink   (input valid, action, key_value, output ready);
endinterface

>>> hw/rtl/lphs_rsp_if.sv
interface lphs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lphs_pkg::STATUS_W-1:0] status;
  logic [lphs_pkg::SLOT_W-1:0]   slot_index;
  logic [lphs_pkg::USED_W-1:0]   entries_used;

  modport source (output valid, status, slot_index, entries_used, input ready);
  modport sink   (input valid, status, slot_index, entries_used, output ready);
endinterface

>>> hw/rtl/lphs_ctrl.sv
module lphs_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [lphs_pkg::ACT_W-1:0] req_action,
  output logic                       req_ready,
  input  lphs_pkg::dp_sts_t          sts,
  output lphs_pkg::dp_cmd_t          cmd
);

  lphs_pkg::ctrl_state_t state, state_next;
  logic                  is_insert;
  logic                  accept;

  assign accept = req_valid && (state == lphs_pkg::S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lphs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Remember which probe kind follows the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      is_insert <= 1'b0;
    end else if (accept) begin
      is_insert <= (req_action == lphs_pkg::ACT_INSERT);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lphs_pkg::S_IDLE: begin
        if (accept) begin
          case (req_action) inside
            lphs_pkg::ACT_INSERT, lphs_pkg::ACT_SEARCH: state_next = lphs_pkg::S_DIV;
            default:                                   state_next = lphs_pkg::S_PUSH;
          endcase
        end
      end
      lphs_pkg::S_DIV: begin
        if (sts.div_last) begin
          state_next = is_insert ? lphs_pkg::S_INSERT : lphs_pkg::S_SEARCH;
        end
      end
      lphs_pkg::S_INSERT: begin
        if (sts.ins_done) state_next = lphs_pkg::S_PUSH;
      end
      lphs_pkg::S_SEARCH: begin
        if (sts.srch_done) state_next = lphs_pkg::S_PUSH;
      end
      lphs_pkg::S_PUSH: begin
        if (!sts.out_busy) state_next = lphs_pkg::S_IDLE;
      end
      default: state_next = lphs_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready     = (state == lphs_pkg::S_IDLE);
    cmd           = '0;
    cmd.start     = accept;
    cmd.clear     = accept && (req_action == lphs_pkg::ACT_CLEAR);
    cmd.misc      = accept && !(req_action == lphs_pkg::ACT_INSERT ||
                                req_action == lphs_pkg::ACT_SEARCH ||
                                req_action == lphs_pkg::ACT_CLEAR);
    cmd.div_step  = (state == lphs_pkg::S_DIV);
    cmd.ins_step  = (state == lphs_pkg::S_INSERT);
    cmd.srch_step = (state == lphs_pkg::S_SEARCH);
    cmd.push      = (state == lphs_pkg::S_PUSH) && !sts.out_busy;
  end

endmodule

>>> hw/rtl/lphs_dp.sv
module lphs_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lphs_pkg::SIZE_W-1:0]   cfg_data,
  input  logic [lphs_pkg::KEY_W-1:0]    key_value,
  input  lphs_pkg::dp_cmd_t             cmd,
  output lphs_pkg::dp_sts_t             sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lphs_pkg::STATUS_W-1:0] out_status,
  output logic [lphs_pkg::SLOT_W-1:0]   out_slot,
  output logic [lphs_pkg::USED_W-1:0]   out_used
);

  localparam int DEPTH = lphs_pkg::TABLE_DEPTH;
  localparam int IW    = lphs_pkg::IDX_W;
  localparam int CW    = lphs_pkg::CNT_W;
  localparam int RW    = lphs_pkg::REM_W;
  localparam int KW    = lphs_pkg::KEY_W;

  logic [lphs_pkg::SIZE_W-1:0]   size_cfg;
  logic [CW-1:0]                 eff_size;
  logic [CW-1:0]                 size_r;
  logic [KW-1:0]                 key_r;
  logic [lphs_pkg::DSH_W-1:0]    dsh;
  logic [CW-1:0]                 rem;
  logic [CW-1:0]                 rem_new;
  logic [lphs_pkg::DCNT_W-1:0]   dcnt;
  logic [IW-1:0]                 idx;
  logic [IW-1:0]                 idx_wrap;
  logic [CW-1:0]                 idx_inc;
  logic [CW-1:0]                 n;
  logic [IW-1:0]                 idx_q;
  logic                          valid_q;
  logic [KW-1:0]                 key_q;
  logic                          b_live;
  logic [DEPTH-1:0]              slot_valid;
  logic [CW-1:0]                 count;
  logic [lphs_pkg::STATUS_W-1:0] res_status;
  logic [IW-1:0]                 res_slot;
  logic [KW-1:0]                 key_mem [DEPTH];

  logic issue, ins_empty, ins_full, srch_found, srch_miss, do_write;

  // Effective size: zero acts as one, oversize clamps to the depth
  always_comb begin
    if (size_cfg == '0) begin
      eff_size = CW'(1);
    end else if (32'(size_cfg) > 32'(DEPTH)) begin
      eff_size = CW'(DEPTH);
    end else begin
      eff_size = CW'(size_cfg);
    end
  end

  // Remainder step: restoring, DIV_BITS bits per cycle
  always_comb begin
    logic [RW-1:0] r;
    r = RW'(rem);
    for (int b = 0; b < lphs_pkg::DIV_BITS; b++) begin
      r = {r[CW-1:0], dsh[lphs_pkg::DSH_W-1-b]};
      if (r >= RW'(size_r)) r = r - RW'(size_r);
    end
    rem_new = r[CW-1:0];
  end

  // Probe address advance with wrap at the active size
  assign idx_inc  = CW'(idx) + CW'(1);
  assign idx_wrap = (idx_inc == size_r) ? '0 : idx_inc[IW-1:0];

  // Probe status
  assign issue      = (n < size_r);
  assign ins_full   = !issue;
  assign ins_empty  = !slot_valid[idx];
  assign do_write   = cmd.ins_step && !ins_full && ins_empty;
  assign srch_found = b_live && valid_q && (key_q == key_r);
  assign srch_miss  = (b_live && !valid_q) || (!b_live && !issue);

  assign sts.div_last  = (dcnt == lphs_pkg::DCNT_W'(lphs_pkg::DIV_STEPS - 1));
  assign sts.ins_done  = ins_full || ins_empty;
  assign sts.srch_done = srch_found || srch_miss;
  assign sts.out_busy  = out_valid && !out_ready;

  // Size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= lphs_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_cfg <= cfg_data;
    end
  end

  // Remainder unit
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r  <= key_value;
      size_r <= eff_size;
      dsh    <= lphs_pkg::DSH_W'(key_value);
      rem    <= '0;
      dcnt   <= '0;
    end else if (cmd.div_step) begin
      dsh  <= dsh << lphs_pkg::DIV_BITS;
      rem  <= rem_new;
      dcnt <= dcnt + 1'b1;
    end
  end

  // Probe pointer and compare stage payload
  always_ff @(posedge clk) begin
    if (cmd.div_step && sts.div_last) begin
      idx <= rem_new[IW-1:0];
      n   <= '0;
    end else if ((cmd.ins_step && !sts.ins_done) || (cmd.srch_step && issue)) begin
      idx <= idx_wrap;
      n   <= n + 1'b1;
    end
    if (cmd.srch_step && issue) begin
      idx_q   <= idx;
      valid_q <= slot_valid[idx];
    end
  end

  // Compare stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      b_live <= 1'b0;
    end else if (cmd.div_step) begin
      b_live <= 1'b0;
    end else if (cmd.srch_step) begin
      b_live <= issue;
    end
  end

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_write) key_mem[idx] <= key_r;
    if (cmd.srch_step && issue) key_q <= key_mem[idx];
  end

  // Slot valid bits and occupancy count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      slot_valid <= '0;
      count      <= '0;
    end else if (do_write) begin
      slot_valid[idx] <= 1'b1;
      count           <= count + 1'b1;
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      res_status <= lphs_pkg::ST_CLEARED;
      res_slot   <= '0;
    end else if (cmd.misc) begin
      res_status <= lphs_pkg::ST_NOT_FOUND;
      res_slot   <= '0;
    end else if (cmd.ins_step && ins_full) begin
      res_status <= lphs_pkg::ST_FULL;
      res_slot   <= '0;
    end else if (do_write) begin
      res_status <= lphs_pkg::ST_INSERTED;
      res_slot   <= idx;
    end else if (cmd.srch_step && srch_found) begin
      res_status <= lphs_pkg::ST_FOUND;
      res_slot   <= idx_q;
    end else if (cmd.srch_step && srch_miss) begin
      res_status <= lphs_pkg::ST_NOT_FOUND;
      res_slot   <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_status <= res_status;
      out_slot   <= lphs_pkg::SLOT_W'(res_slot);
      out_used   <= lphs_pkg::USED_W'(count);
    end
  end

endmodule

>>> hw/rtl/linear_probe_hash_set.sv
// Open-addressing hash set with linear probing over a table of TABLE_DEPTH
// slots, of which cfg_data (written with cfg_we while idle) selects how many
// are in use; zero acts as one and values above the depth act as the depth.
// Each request inserts, searches or clears, and returns exactly one response
// with a status, a slot and the occupied count. One request is worked at a
// time: insert and search first run the key through the key-modulo unit (two
// dividend bits per cycle), then probe one slot per cycle, search through
// the single registered read port of the key memory. Clear and unused actions
// skip the modulo unit and go straight to the response. The response sits in
// an output register, so the next request is accepted while an earlier
// response still waits to be taken.
module linear_probe_hash_set (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lphs_pkg::SIZE_W-1:0] cfg_data,
  lphs_req_if.sink                    req,
  lphs_rsp_if.source                  rsp
);

  lphs_pkg::dp_cmd_t cmd;
  lphs_pkg::dp_sts_t sts;

  // Sequencer
  lphs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Table, remainder unit and response register
  lphs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .key_value  (req.key_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .out_status (rsp.status),
    .out_slot   (rsp.slot_index),
    .out_used   (rsp.entries_used)
  );

endmodule

>>> hw/rtl/lphs_checker.sv
module lphs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [lphs_pkg::STATUS_W-1:0] rsp_status,
  input logic [lphs_pkg::SLOT_W-1:0]   rsp_slot_index,
  input logic [lphs_pkg::USED_W-1:0]   rsp_entries_used
);

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_slot_index) && $stable(rsp_entries_used))
    else $error("response changed while stalled");

  // Clear leaves the table empty
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == lphs_pkg::ST_CLEARED |-> rsp_entries_used == '0)
    else $error("clear reported nonzero occupancy");

  // Only inserted and found carry a slot
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == lphs_pkg::ST_FULL ||
                  rsp_status == lphs_pkg::ST_NOT_FOUND ||
                  rsp_status == lphs_pkg::ST_CLEARED) |-> rsp_slot_index == '0)
    else $error("slot nonzero on a slotless status");

  // Occupancy never exceeds the table
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp_entries_used) <= 32'(lphs_pkg::TABLE_DEPTH))
    else $error("occupancy above table depth");

  // An insert response always reports at least one entry
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == lphs_pkg::ST_INSERTED |-> rsp_entries_used != '0)
    else $error("insert reported empty table");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_slot_index   (rsp.slot_index),
  .rsp_entries_used (rsp.entries_used)
);
